@@ design/lsr_pkg.sv @@
`timescale 1ns / 1ps

package lsr_pkg;

	localparam int FRAC_BITS = 32;
	localparam int DW        = 64;
	localparam int HW        = DW / 2;
	localparam int PW        = 2 * DW;
	localparam int SW        = DW + FRAC_BITS;
	localparam int IDXW      = 8;

	typedef enum logic [IDXW-1:0] {
		REG_DENSITY  = 8'd0,
		REG_PRESSURE = 8'd1
	} reg_idx_t;

	typedef struct packed {
		logic signed [DW-1:0] gas_concentration;
		logic signed [DW-1:0] pore_pressure;
		logic signed [DW-1:0] inv_desorption_time;
		logic signed [DW-1:0] inv_adsorption_time;
	} in_item_t;

	typedef struct packed {
		logic signed [DW-1:0] mass_rate;
		logic signed [DW-1:0] rate_slope_conc;
		logic signed [DW-1:0] rate_slope_pressure;
		logic                 zero_divisor;
	} out_item_t;

	typedef struct packed {
		logic [DW-1:0] ll;
		logic [DW-1:0] lh;
		logic [DW-1:0] hl;
		logic [DW-1:0] hh;
	} pp_t;

	// Four 32x32 partial products of an unsigned 64x64 multiply.
	function automatic pp_t pp_mul(input logic [DW-1:0] a, input logic [DW-1:0] b);
		pp_t r;
		r.ll = a[HW-1:0] * b[HW-1:0];
		r.lh = a[HW-1:0] * b[DW-1:HW];
		r.hl = a[DW-1:HW] * b[HW-1:0];
		r.hh = a[DW-1:HW] * b[DW-1:HW];
		return r;
	endfunction

	function automatic logic [PW-1:0] pp_sum(input pp_t p);
		return {{DW{1'b0}}, p.ll} + ({{DW{1'b0}}, p.lh} << HW)
			+ ({{DW{1'b0}}, p.hl} << HW) + {p.hh, {DW{1'b0}}};
	endfunction

	// Magnitude plus sign into a two's complement word one bit wider.
	function automatic logic [PW:0] apply_sign(input logic [PW-1:0] m, input logic neg);
		logic [PW:0] r;
		r = {1'b0, m};
		return neg ? ({(PW+1){1'b0}} - r) : r;
	endfunction

	function automatic logic [DW-1:0] sat64(input logic [PW:0] a);
		if (&a[PW:DW-1] || ~|a[PW:DW-1])
			return a[DW-1:0];
		return a[PW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	endfunction

	function automatic logic [DW-1:0] abs64(input logic [DW-1:0] x);
		return x[DW-1] ? (~x + 1'b1) : x;
	endfunction

	// One restoring division step: returns the quotient bit and the new remainder.
	function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nbit,
			input logic [DW-1:0] dv);
		logic [DW:0] t;
		logic [DW:0] s;
		t = {rem, nbit};
		s = t - {1'b0, dv};
		if (t >= {1'b0, dv})
			return {1'b1, s[DW-1:0]};
		return {1'b0, t[DW-1:0]};
	endfunction

endpackage

@@ design/lsr_if.sv @@
`timescale 1ns / 1ps

interface lsr_in_if;
	import lsr_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lsr_out_if;
	import lsr_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lsr_cfg_if;
	import lsr_pkg::*;
	logic            valid;
	logic            ready;
	logic [IDXW-1:0] index;
	logic [DW-1:0]   value;
	modport source(output valid, output index, output value, input ready);
	modport sink(input valid, input index, input value, output ready);
endinterface

@@ design/langmuir_sorption_rate.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle; the pipeline only stalls when the output item is not taken.
// The depth is set by two bit-serial restoring dividers, 128 and 96 stages long.
// Reset (arst_n low, asynchronous) empties the pipeline, sets the density register to zero
// and the Langmuir pressure register to 1.0; no clearing pass is needed.
module langmuir_sorption_rate (
	input  logic              clk,
	input  logic              arst_n,
	lsr_in_if.sink            in_ch,
	lsr_out_if.source         out_ch,
	lsr_cfg_if.sink           cfg
);
	import lsr_pkg::*;

	// Sideband carried through the first divider.
	typedef struct packed {
		logic [DW-1:0] conc;
		logic [DW-1:0] idt;
		logic [DW-1:0] iat;
		logic          p_neg;
		logic          d_neg;
		logic          zero;
		logic [DW-1:0] dabs;
	} side1_t;

	// Sideband carried through the second divider.
	typedef struct packed {
		logic [DW-1:0] rate0;
		logic [DW-1:0] tc;
		logic          zero;
		logic          s_neg;
		logic [DW-1:0] dabs;
	} side2_t;

	// Configuration registers. Only the low 63 bits of a write are kept, so both
	// values are always non-negative.
	logic [DW-2:0] density_q;
	logic [DW-2:0] pressure_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_q  <= '0;
			pressure_q <= (DW-1)'(1) << FRAC_BITS;
		end else if (cfg.valid) begin
			if (cfg.index == REG_DENSITY)
				density_q <= cfg.value[DW-2:0];
			else if (cfg.index == REG_PRESSURE)
				pressure_q <= cfg.value[DW-2:0];
		end
	end

	// The whole pipeline moves together; it holds when the output item waits.
	logic out_v_q;
	logic adv;

	assign adv         = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	// Stage 1: the denominator D = Langmuir pressure + p is exact in 65 bits and its
	// magnitude always fits in 64 bits. Magnitudes feed the unsigned datapath.
	logic signed [DW:0] den;
	logic [DW:0]        den_mag;

	assign den     = $signed({2'b00, pressure_q}) +
		$signed({in_ch.data.pore_pressure[DW-1], in_ch.data.pore_pressure});
	assign den_mag = den[DW] ? ((DW+1)'(0) - den) : den;

	logic          v_s1;
	side1_t        sd_s1;
	logic [DW-1:0] pabs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1.conc  <= in_ch.data.gas_concentration;
			sd_s1.idt   <= in_ch.data.inv_desorption_time;
			sd_s1.iat   <= in_ch.data.inv_adsorption_time;
			sd_s1.p_neg <= in_ch.data.pore_pressure[DW-1];
			sd_s1.d_neg <= den[DW];
			sd_s1.zero  <= (den == '0);
			sd_s1.dabs  <= den_mag[DW-1:0];
			pabs_s1     <= abs64(in_ch.data.pore_pressure);
		end
	end

	// Stage 2: partial products of density * |p| and density * Langmuir pressure.
	logic   v_s2;
	side1_t sd_s2;
	pp_t    ppe_s2;
	pp_t    ppt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2  <= sd_s1;
			ppe_s2 <= pp_mul({1'b0, density_q}, pabs_s1);
			ppt_s2 <= pp_mul({1'b0, density_q}, {1'b0, pressure_q});
		end
	end

	// First divider: |density * p| / |D| and density * Langmuir pressure / |D| share
	// the divisor and run side by side, one quotient bit per stage. Entry 0 is stage 3,
	// where the partial products are summed. The numerator register shifts left and
	// takes the quotient bits in at the bottom.
	logic          dv1_v_s  [0:PW];
	side1_t        dv1_sd_s [0:PW];
	logic [PW-1:0] dv1_ne_s [0:PW];
	logic [PW-1:0] dv1_nt_s [0:PW];
	logic [DW-1:0] dv1_re_s [0:PW];
	logic [DW-1:0] dv1_rt_s [0:PW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv1_v_s[0] <= 1'b0;
		else if (adv)
			dv1_v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv1_sd_s[0] <= sd_s2;
			dv1_ne_s[0] <= pp_sum(ppe_s2);
			dv1_nt_s[0] <= pp_sum(ppt_s2);
			dv1_re_s[0] <= '0;
			dv1_rt_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < PW; k++) begin : g_div1
		logic [DW:0] step_e;
		logic [DW:0] step_t;

		assign step_e = div_step(dv1_re_s[k], dv1_ne_s[k][PW-1], dv1_sd_s[k].dabs);
		assign step_t = div_step(dv1_rt_s[k], dv1_nt_s[k][PW-1], dv1_sd_s[k].dabs);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv1_v_s[k+1] <= 1'b0;
			else if (adv)
				dv1_v_s[k+1] <= dv1_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv1_sd_s[k+1] <= dv1_sd_s[k];
				dv1_ne_s[k+1] <= {dv1_ne_s[k][PW-2:0], step_e[DW]};
				dv1_nt_s[k+1] <= {dv1_nt_s[k][PW-2:0], step_t[DW]};
				dv1_re_s[k+1] <= step_e[DW-1:0];
				dv1_rt_s[k+1] <= step_t[DW-1:0];
			end
		end
	end

	// Stage 4: signed equilibrium E and the difference C - E, exact; signed T.
	logic          v_s4;
	side1_t        sd_s4;
	logic [PW:0]   diff_s4;
	logic [PW:0]   t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= dv1_v_s[PW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s4   <= dv1_sd_s[PW];
			diff_s4 <= {{(PW+1-DW){dv1_sd_s[PW].conc[DW-1]}}, dv1_sd_s[PW].conc}
				- apply_sign(dv1_ne_s[PW], dv1_sd_s[PW].p_neg ^ dv1_sd_s[PW].d_neg);
			t_s4    <= apply_sign(dv1_nt_s[PW], dv1_sd_s[PW].d_neg);
		end
	end

	// Stage 5: saturate, pick the time constant, and set up T * 2^FRAC_BITS / D.
	// Concentration strictly above equilibrium selects desorption; a tie adsorbs.
	logic          desorb;
	logic [DW-1:0] t_sat;

	assign desorb = !diff_s4[PW] && (diff_s4 != '0);
	assign t_sat  = sat64(t_s4);

	logic          dv2_v_s  [0:SW];
	side2_t        dv2_sd_s [0:SW];
	logic [SW-1:0] dv2_n_s  [0:SW];
	logic [DW-1:0] dv2_r_s  [0:SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv2_v_s[0] <= 1'b0;
		else if (adv)
			dv2_v_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv2_sd_s[0].rate0 <= sat64(diff_s4);
			dv2_sd_s[0].tc    <= desorb ? sd_s4.idt : sd_s4.iat;
			dv2_sd_s[0].zero  <= sd_s4.zero;
			dv2_sd_s[0].s_neg <= t_sat[DW-1] ^ sd_s4.d_neg;
			dv2_sd_s[0].dabs  <= sd_s4.dabs;
			dv2_n_s[0]        <= {abs64(t_sat), {FRAC_BITS{1'b0}}};
			dv2_r_s[0]        <= '0;
		end
	end

	for (genvar k = 0; k < SW; k++) begin : g_div2
		logic [DW:0] step;

		assign step = div_step(dv2_r_s[k], dv2_n_s[k][SW-1], dv2_sd_s[k].dabs);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv2_v_s[k+1] <= 1'b0;
			else if (adv)
				dv2_v_s[k+1] <= dv2_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv2_sd_s[k+1] <= dv2_sd_s[k];
				dv2_n_s[k+1]  <= {dv2_n_s[k][SW-2:0], step[DW]};
				dv2_r_s[k+1]  <= step[DW-1:0];
			end
		end
	end

	// Stage 6: the pressure slope is the negated quotient, saturated.
	logic          v_s6;
	logic [DW-1:0] rate0_s6;
	logic [DW-1:0] slope0_s6;
	logic [DW-1:0] tc_s6;
	logic          zero_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= dv2_v_s[SW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rate0_s6  <= dv2_sd_s[SW].rate0;
			slope0_s6 <= sat64(apply_sign({{(PW-SW){1'b0}}, dv2_n_s[SW]},
				!dv2_sd_s[SW].s_neg));
			tc_s6     <= dv2_sd_s[SW].tc;
			zero_s6   <= dv2_sd_s[SW].zero;
		end
	end

	// Stage 7: magnitudes and product signs for the final scaling.
	logic          v_s7;
	logic [DW-1:0] ra_s7;
	logic [DW-1:0] sa_s7;
	logic [DW-1:0] ta_s7;
	logic          rneg_s7;
	logic          sneg_s7;
	logic [DW-1:0] tc_s7;
	logic          zero_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (adv)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s7   <= abs64(rate0_s6);
			sa_s7   <= abs64(slope0_s6);
			ta_s7   <= abs64(tc_s6);
			rneg_s7 <= rate0_s6[DW-1] ^ tc_s6[DW-1];
			sneg_s7 <= slope0_s6[DW-1] ^ tc_s6[DW-1];
			tc_s7   <= tc_s6;
			zero_s7 <= zero_s6;
		end
	end

	// Stage 8: partial products of both scalings.
	logic          v_s8;
	pp_t           ppr_s8;
	pp_t           pps_s8;
	logic          rneg_s8;
	logic          sneg_s8;
	logic [DW-1:0] tc_s8;
	logic          zero_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (adv)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ppr_s8  <= pp_mul(ra_s7, ta_s7);
			pps_s8  <= pp_mul(sa_s7, ta_s7);
			rneg_s8 <= rneg_s7;
			sneg_s8 <= sneg_s7;
			tc_s8   <= tc_s7;
			zero_s8 <= zero_s7;
		end
	end

	// Stage 9: full signed products.
	logic          v_s9;
	logic [PW:0]   pr_s9;
	logic [PW:0]   ps_s9;
	logic [DW-1:0] tc_s9;
	logic          zero_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (adv)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s9   <= apply_sign(pp_sum(ppr_s8), rneg_s8);
			ps_s9   <= apply_sign(pp_sum(pps_s8), sneg_s8);
			tc_s9   <= tc_s8;
			zero_s9 <= zero_s8;
		end
	end

	// Output register: the arithmetic shift rounds toward minus infinity, then the
	// result saturates. A zero denominator forces all values to zero and sets the flag.
	logic [PW:0] pr_sh;
	logic [PW:0] ps_sh;
	out_item_t   out_q;

	assign pr_sh = $signed(pr_s9) >>> FRAC_BITS;
	assign ps_sh = $signed(ps_s9) >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s9) begin
				out_q.mass_rate           <= '0;
				out_q.rate_slope_conc     <= '0;
				out_q.rate_slope_pressure <= '0;
				out_q.zero_divisor        <= 1'b1;
			end else begin
				out_q.mass_rate           <= sat64(pr_sh);
				out_q.rate_slope_conc     <= tc_s9;
				out_q.rate_slope_pressure <= sat64(ps_sh);
				out_q.zero_divisor        <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

endmodule
